@@ rtl/npc_pkg.sv @@
`default_nettype none
package npc_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_GRAY  = 2'd2;

	localparam int COMP_W  = 8;
	localparam int ERR_W   = 19;
	localparam int DIV_CNT = 3;

	// command bundle from the controller to the datapath
	typedef struct packed {
		logic load;      // latch the item, clear search and build state
		logic wr_entry;  // store one expanded entry
		logic div_step;  // one bit of 255 / m
		logic gray_step; // store one ramp entry, advance the ramp
		logic issue;     // issue one palette read into the scan pipe
		logic emit;      // register the result and strobe it
	} npc_cmd_t;

	// status bundle from the datapath to the controller
	typedef struct packed {
		logic cnt_zero;
		logic issue_last;
		logic div_last;
		logic gray_last;
		logic pipe_empty;
	} npc_sts_t;

	// v*255/63 for a 6-bit level: 4v plus floor(v/21)
	function automatic logic [COMP_W-1:0] expand_level(input logic [5:0] v);
		logic [1:0] frac;
		if (v >= 6'd63) begin
			frac = 2'd3;
		end else if (v >= 6'd42) begin
			frac = 2'd2;
		end else if (v >= 6'd21) begin
			frac = 2'd1;
		end else begin
			frac = 2'd0;
		end
		return {v, 2'b00} + {6'd0, frac};
	endfunction

endpackage
`default_nettype wire

@@ rtl/npc_ctrl.sv @@
`default_nettype none
module npc_ctrl
	import npc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] operation,
	input  wire npc_sts_t   sts,
	output npc_cmd_t        cmd,
	output logic            busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WRITE = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_GRAY  = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.load      = accept;
		cmd.wr_entry  = (state_q == S_WRITE);
		cmd.div_step  = (state_q == S_DIV);
		cmd.gray_step = (state_q == S_GRAY);
		cmd.issue     = (state_q == S_SCAN) && !sts.cnt_zero;
		cmd.emit      = (state_q == S_DONE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (operation)
						OP_WRITE: state_d = S_WRITE;
						OP_QUERY: state_d = S_SCAN;
						OP_GRAY:  state_d = S_DIV;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_WRITE: state_d = S_DONE;
			S_DIV: begin
				if (sts.div_last) state_d = S_GRAY;
			end
			S_GRAY: begin
				if (sts.gray_last) state_d = S_DONE;
			end
			S_SCAN: begin
				if (sts.cnt_zero) begin
					state_d = S_DONE;
				end else if (sts.issue_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.pipe_empty) state_d = S_DONE;
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/npc_dpath.sv @@
`default_nettype none
module npc_dpath
	import npc_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire npc_cmd_t          cmd,
	output npc_sts_t               sts,
	input  wire logic [7:0]        entry_index,
	input  wire logic [COMP_W-1:0] red,
	input  wire logic [COMP_W-1:0] green,
	input  wire logic [COMP_W-1:0] blue,
	input  wire logic [7:0]        max_index,
	output logic                   done,
	output logic [7:0]             best_index,
	output logic [ERR_W-1:0]       best_error,
	output logic                   found
);

	localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
	localparam int ENT_W = 3 * COMP_W;

	// latched item
	logic [COMP_W-1:0] red_q, green_q, blue_q;
	logic [IDX_W-1:0]  widx_q;
	logic              wen_ok_q;
	logic [7:0]        gmax_q;

	// palette store
	logic [ENT_W-1:0]           mem_q [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]           count_q;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_wa;
	logic [ENT_W-1:0]           mem_wd;

	// divider and ramp
	logic [8:0]         div_rem_q;
	logic [7:0]         div_quo_q;
	logic [DIV_CNT-1:0] div_cnt_q;
	logic [8:0]         rem_sh;
	logic               div_ge;
	logic [IDX_W-1:0]   gray_i_q;
	logic [7:0]         gray_v_q;
	logic [7:0]         gray_r_q;
	logic [8:0]         gray_sum;
	logic               gray_wrap;

	// scan pipe
	logic [IDX_W-1:0]  rd_addr_q;
	logic              p_s1, vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [ENT_W-1:0]  rd_data_s1;
	logic [ENT_W-1:0]  ent;
	logic [COMP_W-1:0] d_r, d_g, d_b;
	logic              p_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [15:0]       sq_r_s2, sq_g_s2, sq_b_s2;
	logic [16:0]       sum_rg;
	logic [ERR_W-1:0]  err;
	logic [IDX_W-1:0]  best_i_q;
	logic [ERR_W-1:0]  best_e_q;
	logic              have_q;

	logic [7:0]         best_index_q;
	logic [ERR_W-1:0]   best_error_q;
	logic               found_q;
	logic               done_q;

	assign sts.cnt_zero   = (count_q == '0);
	assign sts.issue_last = ((CNT_W'(rd_addr_q) + CNT_W'(1)) == count_q);
	assign sts.div_last   = (div_cnt_q == '1);
	assign sts.gray_last  = (8'(gray_i_q) == gmax_q);
	assign sts.pipe_empty = !p_s1 && !p_s2;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			red_q    <= red;
			green_q  <= green;
			blue_q   <= blue;
			widx_q   <= entry_index[IDX_W-1:0];
			wen_ok_q <= ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
			if ({1'b0, max_index} > 9'(PALETTE_ENTRIES - 1)) begin
				gmax_q <= 8'(PALETTE_ENTRIES - 1);
			end else begin
				gmax_q <= max_index;
			end
		end
	end

	// restoring divide of 255 by m, a bit a cycle
	assign rem_sh = {div_rem_q[7:0], 1'b1};
	assign div_ge = (rem_sh >= {1'b0, gmax_q});

	// ramp: value and remainder of i*255/m, advanced by quotient and remainder
	assign gray_sum  = {1'b0, gray_r_q} + {1'b0, div_rem_q[7:0]};
	assign gray_wrap = (gray_sum >= {1'b0, gmax_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CNT'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_rem_q <= '0;
			div_quo_q <= '0;
			gray_i_q  <= '0;
			gray_v_q  <= '0;
			gray_r_q  <= '0;
		end else begin
			if (cmd.div_step) begin
				div_rem_q <= div_ge ? (rem_sh - {1'b0, gmax_q}) : rem_sh;
				div_quo_q <= {div_quo_q[6:0], div_ge};
			end
			if (cmd.gray_step) begin
				gray_i_q <= gray_i_q + IDX_W'(1);
				gray_r_q <= gray_wrap ? 8'(gray_sum - {1'b0, gmax_q}) : gray_sum[7:0];
				gray_v_q <= gray_v_q + div_quo_q + {7'd0, gray_wrap};
			end
		end
	end

	// store write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = gray_i_q;
		mem_wd = {gray_v_q, gray_v_q, gray_v_q};
		if (cmd.gray_step) begin
			mem_we = 1'b1;
		end else if (cmd.wr_entry && wen_ok_q) begin
			mem_we = 1'b1;
			mem_wa = widx_q;
			mem_wd = {expand_level(red_q[5:0]), expand_level(green_q[5:0]),
				expand_level(blue_q[5:0])};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem_q[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (mem_we) begin
				valid_q[mem_wa] <= 1'b1;
			end
			if (cmd.wr_entry && wen_ok_q) begin
				count_q <= CNT_W'(PALETTE_ENTRIES);
			end else if (cmd.gray_step && sts.gray_last) begin
				count_q <= CNT_W'(gmax_q) + CNT_W'(1);
			end
		end
	end

	// scan pipe: read, square, compare
	assign ent = vld_s1 ? rd_data_s1 : '0;
	assign d_r = (red_q > ent[ENT_W-1 -: COMP_W]) ? red_q - ent[ENT_W-1 -: COMP_W]
		: ent[ENT_W-1 -: COMP_W] - red_q;
	assign d_g = (green_q > ent[2*COMP_W-1 -: COMP_W]) ? green_q - ent[2*COMP_W-1 -: COMP_W]
		: ent[2*COMP_W-1 -: COMP_W] - green_q;
	assign d_b = (blue_q > ent[COMP_W-1:0]) ? blue_q - ent[COMP_W-1:0]
		: ent[COMP_W-1:0] - blue_q;
	assign sum_rg = 17'(sq_r_s2) + 17'(sq_g_s2);
	assign err    = 19'({sum_rg, 1'b0}) + 19'(sq_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1      <= 1'b0;
			p_s2      <= 1'b0;
			have_q    <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			p_s1 <= cmd.issue;
			p_s2 <= p_s1;
			if (cmd.load) begin
				have_q    <= 1'b0;
				rd_addr_q <= '0;
			end else begin
				if (cmd.issue) begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
				end
				if (p_s2 && (!have_q || err < best_e_q)) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_addr_q;
		vld_s1  <= valid_q[rd_addr_q];
		idx_s2  <= idx_s1;
		sq_r_s2 <= 16'(d_r) * 16'(d_r);
		sq_g_s2 <= 16'(d_g) * 16'(d_g);
		sq_b_s2 <= 16'(d_b) * 16'(d_b);
		if (p_s2 && (!have_q || err < best_e_q)) begin
			best_i_q <= idx_s2;
			best_e_q <= err;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			found_q      <= 1'b0;
			best_index_q <= '0;
			best_error_q <= '0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.emit) begin
				found_q      <= have_q;
				best_index_q <= have_q ? 8'(best_i_q) : 8'd0;
				best_error_q <= have_q ? best_e_q : '0;
			end
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign best_index = best_index_q;
	assign best_error = best_error_q;

endmodule
`default_nettype wire

@@ rtl/nearest_palette_color_search.sv @@
// Nearest palette colour search. Holds up to PALETTE_ENTRIES RGB entries,
// valid flags and a scan count; reset clears the flags and count but not the
// entries. Pulse start while busy is low to transfer one command: write one
// entry from 6-bit levels, build a grey ramp over entries 0..m, or query the
// nearest entry by the error 2*(dr^2+dg^2)+db^2 (first index wins a tie).
// Every command, whatever its code, yields exactly one result, shown for a
// single cycle with done high; the receiver cannot stall it, so capture it on
// that cycle. Non-queries and queries on an empty palette return found low
// with index and error zero. A query is paced by the single read port of the
// palette store being scanned an entry a cycle through a three-stage
// read/square/compare pipe; a grey build runs the bit-serial 255/m divide
// followed by one store write per entry. busy stays high from acceptance
// until the done cycle.
`default_nettype none
module nearest_palette_color_search
	import npc_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        operation,
	input  wire logic [7:0]        entry_index,
	input  wire logic [COMP_W-1:0] red,
	input  wire logic [COMP_W-1:0] green,
	input  wire logic [COMP_W-1:0] blue,
	input  wire logic [7:0]        max_index,
	output logic                   done,
	output logic [7:0]             best_index,
	output logic [ERR_W-1:0]       best_error,
	output logic                   found
);

	npc_cmd_t cmd;
	npc_sts_t sts;

	// sequence each command: dispatch, run the divide, ramp or scan, drain, emit
	npc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	// palette store, grey ramp generator, scan pipe and result register
	npc_dpath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.max_index   (max_index),
		.done        (done),
		.best_index  (best_index),
		.best_error  (best_error),
		.found       (found)
	);

endmodule
`default_nettype wire
